>>> rtl/lrs_pkg.sv
// ----------------------------------------------------------------------------
// lrs_pkg
// Shared constants and control types for the LRU recency stack unit.
// ----------------------------------------------------------------------------
package lrs_pkg;

    // Stack geometry
    localparam int CAPACITY = 16;
    localparam int KEY_W    = 16;
    localparam int SIZE_W   = 5;
    localparam int SLOT_W   = 4;
    localparam int PTR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int EFF_W    = (SIZE_W > CNT_W) ? SIZE_W : CNT_W;

    // Reset value of the active size register
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

    // Function codes of an input word
    localparam logic FUNC_ACCESS = 1'b0;
    localparam logic FUNC_DUMP   = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic update;     // apply an access to the stack
        logic cnt_clr;    // restart the dump slot counter
        logic cnt_inc;    // advance the dump slot counter
        logic load;       // load the output register from the current slot
        logic load_last;  // the loaded slot closes the dump
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;   // output register can take a word this cycle
        logic last_slot;  // dump counter sits on the last active slot
    } t_sts;

endpackage

>>> rtl/lru_recency_stack_unit.sv
// ----------------------------------------------------------------------------
// lru_recency_stack_unit
// LRU recency stack: access words update the stack, dump words read it out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries i_func and i_key.
//   An access word (func 0) moves the key to slot 0 in the cycle it is
//   accepted; it gives no output word. Accesses run at one word per cycle
//   outside a dump. A dump word (func 1) streams one output word per
//   active slot, slot 0 first, with o_last on the final slot. Once the
//   dump is accepted, the input stays stalled until the last slot is
//   loaded into the output register; a load waits while the receiver
//   stalls a held word. The dump counter steps through the stack cells.
//   Output channel (o_out_valid / i_out_stall) is registered; a stalled
//   word holds until taken, and an access may be accepted meanwhile.
//   i_cfg_we writes i_cfg_data into the active size (1..16, 0 reads as 1,
//   above 16 as 16); write it only while the block is idle.
//   Synchronous reset clears the stack to zeros, sets active size to 16
//   and empties the output register.
// ----------------------------------------------------------------------------
module lru_recency_stack_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [lrs_pkg::SIZE_W-1:0] i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_func,
    input  logic [lrs_pkg::KEY_W-1:0]  i_key,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [lrs_pkg::KEY_W-1:0]  o_entry_value,
    output logic [lrs_pkg::SLOT_W-1:0] o_slot_index,
    output logic                       o_last
);
    import lrs_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Controller
    lrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath
    lrs_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_key         (i_key),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_entry_value (o_entry_value),
        .o_slot_index  (o_slot_index),
        .o_last        (o_last)
    );

endmodule

>>> rtl/lrs_ctrl.sv
// ----------------------------------------------------------------------------
// lrs_ctrl
// Controller: accepts input words and sequences a dump slot by slot.
// ----------------------------------------------------------------------------
module lrs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_func,
    output logic          o_in_stall,
    input  lrs_pkg::t_sts i_sts,
    output lrs_pkg::t_cmd o_cmd
);
    import lrs_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    // Input is taken only between dumps
    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;

    // Command decode and next state
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_func == FUNC_DUMP) begin
                        o_cmd.cnt_clr = 1'b1;
                        n_state       = S_DUMP;
                    end else begin
                        o_cmd.update = 1'b1;
                    end
                end
            end
            S_DUMP: begin
                if (i_sts.out_free) begin
                    o_cmd.load      = 1'b1;
                    o_cmd.load_last = i_sts.last_slot;
                    if (i_sts.last_slot) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.cnt_inc = 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/lrs_datapath.sv
// ----------------------------------------------------------------------------
// lrs_datapath
// Recency stack cells, active size register, dump counter and output register.
// ----------------------------------------------------------------------------
module lrs_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [lrs_pkg::SIZE_W-1:0] i_cfg_data,
    input  logic [lrs_pkg::KEY_W-1:0]  i_key,
    input  lrs_pkg::t_cmd              i_cmd,
    output lrs_pkg::t_sts              o_sts,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [lrs_pkg::KEY_W-1:0]  o_entry_value,
    output logic [lrs_pkg::SLOT_W-1:0] o_slot_index,
    output logic                       o_last
);
    import lrs_pkg::*;

    logic [SIZE_W-1:0] r_active_size;
    logic [KEY_W-1:0]  r_stack [CAPACITY];
    logic [KEY_W-1:0]  n_stack [CAPACITY];
    logic [PTR_W-1:0]  r_cnt;
    logic              r_out_valid;
    logic [KEY_W-1:0]  r_out_value;
    logic [PTR_W-1:0]  r_out_index;
    logic              r_out_last;

    logic [EFF_W-1:0]  size_ext;
    logic [EFF_W-1:0]  eff_size;
    logic [PTR_W-1:0]  last_idx;
    logic [CAPACITY-1:0] active;
    logic [CAPACITY-1:0] match;
    logic [CAPACITY-1:0] shift_en;
    logic              hit;

    // Effective size clamped to 1..CAPACITY
    always_comb begin
        size_ext = EFF_W'(r_active_size);
        if (size_ext == '0) begin
            eff_size = EFF_W'(1);
        end else if (size_ext > EFF_W'(CAPACITY)) begin
            eff_size = EFF_W'(CAPACITY);
        end else begin
            eff_size = size_ext;
        end
        last_idx = PTR_W'(eff_size - EFF_W'(1));
    end

    // Per-cell compare; a cell shifts when its index is at or below the victim slot
    always_comb begin
        for (int j = 0; j < CAPACITY; j++) begin
            active[j] = (EFF_W'(j) < eff_size);
            match[j]  = active[j] && (r_stack[j] == i_key);
        end
        hit = |match;
        for (int j = 0; j < CAPACITY; j++) begin
            shift_en[j] = hit ? (|(match >> j)) : active[j];
        end
    end

    // Next stack contents
    always_comb begin
        for (int j = 0; j < CAPACITY; j++) begin
            n_stack[j] = r_stack[j];
        end
        if (i_cmd.update) begin
            n_stack[0] = i_key;
            for (int j = 1; j < CAPACITY; j++) begin
                if (shift_en[j]) begin
                    n_stack[j] = r_stack[j-1];
                end
            end
        end
    end

    // Stack cells and active size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_size <= SIZE_RESET;
            for (int j = 0; j < CAPACITY; j++) begin
                r_stack[j] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_active_size <= i_cfg_data;
            end
            for (int j = 0; j < CAPACITY; j++) begin
                r_stack[j] <= n_stack[j];
            end
        end
    end

    // Dump slot counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + PTR_W'(1);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_value <= r_stack[r_cnt];
            r_out_index <= r_cnt;
            r_out_last  <= i_cmd.load_last;
        end
    end

    // Status back to the controller
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;
    assign o_sts.last_slot = (r_cnt == last_idx);

    assign o_out_valid   = r_out_valid;
    assign o_entry_value = r_out_value;
    assign o_slot_index  = SLOT_W'(r_out_index);
    assign o_last        = r_out_last;

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LRU recency stack unit. A queue of pending
// access and dump words feeds a clocked driver; the driver updates a
// shadow recency stack on each accepted word and queues the slot words
// that a dump must return. A clocked monitor compares every output word
// with the oldest queued one. The active size is rewritten between phases,
// including out-of-range values, and both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    import lrs_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int NUM_PHASES = 10;
    localparam int PHASE_WORDS = 28;
    localparam int PHASE_SIZES [NUM_PHASES] = '{16, 3, 1, 17, 8, 0, 31, 12, 2, 16};

    typedef struct {
        logic              func;
        logic [KEY_W-1:0]  key;
    } t_stack_op;

    typedef struct {
        logic [KEY_W-1:0]  value;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } t_slot_report;

    // DUT connections; the inputs are all known from time zero
    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              cfg_we     = 1'b0;
    logic [SIZE_W-1:0] cfg_data   = '0;
    logic              in_valid   = 1'b0;
    logic              in_func    = FUNC_ACCESS;
    logic [KEY_W-1:0]  in_key     = '0;
    logic              out_stall  = 1'b0;
    logic              o_in_stall;
    logic              o_out_valid;
    logic [KEY_W-1:0]  o_entry_value;
    logic [SLOT_W-1:0] o_slot_index;
    logic              o_last;

    // Shadow state of the stack and its size register
    logic [KEY_W-1:0]  shadow_stack [CAPACITY];
    logic [SIZE_W-1:0] shadow_size;

    t_stack_op         op_queue[$];
    t_slot_report      slot_expect[$];
    logic [KEY_W-1:0]  key_pool [12];

    // Bench control
    bit                idling = 1'b0;
    bit                hold_request = 1'b0;
    int                send_gap = 0;
    int                stall_left = 0;
    int                hold_left = 0;
    int                idle_cycles = 0;
    bit                took;
    t_stack_op         next_op;

    int                errors = 0;
    int                access_count = 0;
    int                hit_count = 0;
    int                dump_count = 0;
    int                words_checked = 0;
    int                cfg_writes = 0;

    lru_recency_stack_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (in_func),
        .i_key         (in_key),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (out_stall),
        .o_entry_value (o_entry_value),
        .o_slot_index  (o_slot_index),
        .o_last        (o_last)
    );

    always #4 i_clk = ~i_clk;

    // Gap length: mostly none, often short, sometimes long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Keys drawn mostly from a small pool so accesses hit often
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return $urandom_range(0, 1) ? '1 : '0;
        if (r < 3) return KEY_W'($urandom);
        return key_pool[$urandom_range(0, 11)];
    endfunction

    // Apply one accepted word to the shadow stack; a dump queues its slot words
    task automatic apply_op(input logic func, input logic [KEY_W-1:0] key);
        int n;
        int pos;
        bit hit;
        t_slot_report rep;
        n = (shadow_size == 0) ? 1 : ((shadow_size > CAPACITY) ? CAPACITY : int'(shadow_size));
        if (func == FUNC_ACCESS) begin
            hit = 1'b0;
            pos = n - 1;
            // last matching active slot wins
            for (int j = 0; j < n; j++) begin
                if (shadow_stack[j] == key) begin
                    hit = 1'b1;
                    pos = j;
                end
            end
            for (int j = pos; j >= 1; j--) shadow_stack[j] = shadow_stack[j-1];
            shadow_stack[0] = key;
            access_count++;
            if (hit) hit_count++;
        end else begin
            for (int j = 0; j < n; j++) begin
                rep.value = shadow_stack[j];
                rep.slot  = SLOT_W'(j);
                rep.last  = (j == n - 1);
                slot_expect.push_back(rep);
            end
            dump_count++;
        end
    endtask

    task automatic check_slot_word();
        t_slot_report want;
        if (slot_expect.size() == 0) begin
            errors++;
            $display("%0t: slot word with none expected: value %h slot %0d last %b",
                     $time, o_entry_value, o_slot_index, o_last);
        end else begin
            want = slot_expect.pop_front();
            words_checked++;
            if (o_entry_value !== want.value) begin
                errors++;
                $display("%0t: entry_value expected %h actual %h",
                         $time, want.value, o_entry_value);
            end
            if (o_slot_index !== want.slot) begin
                errors++;
                $display("%0t: slot_index expected %0d actual %0d",
                         $time, want.slot, o_slot_index);
            end
            if (o_last !== want.last) begin
                errors++;
                $display("%0t: last expected %b actual %b", $time, want.last, o_last);
            end
        end
    endtask

    // Driver: present pending words, predict on each accepted one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            took = in_valid && !o_in_stall;
            if (took) apply_op(in_func, in_key);
            if (!in_valid || took) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (op_queue.size() > 0) begin
                    next_op = op_queue.pop_front();
                    in_func  <= next_op.func;
                    in_key   <= next_op.key;
                    in_valid <= 1'b1;
                    send_gap = idling ? pick_gap() : 0;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check taken words, drive random stalls and the long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            stall_left = 0;
            hold_left = 0;
        end else begin
            if (o_out_valid && !out_stall) check_slot_word();
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = 150 + $urandom_range(0, 50);
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
                if (idling) stall_left = pick_gap();
            end
        end
    end

    // Watchdog on cycles with no word taken on either channel
    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no progress, %0d slot words still expected",
                         $time, slot_expect.size());
                $display("lru_recency_stack_unit regression: fail");
                $finish;
            end
        end
    end

    task automatic queue_op(input logic func, input logic [KEY_W-1:0] key);
        t_stack_op op;
        op.func = func;
        op.key  = key;
        op_queue.push_back(op);
    endtask

    // Wait until every word is taken and every slot word returned
    task automatic settle();
        do @(negedge i_clk);
        while (op_queue.size() != 0 || in_valid || slot_expect.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] size);
        settle();
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= size;
        shadow_size = size;
        cfg_writes++;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        for (int j = 0; j < CAPACITY; j++) shadow_stack[j] = '0;
        shadow_size = SIZE_RESET;
        for (int j = 0; j < 12; j++) key_pool[j] = (j < 4) ? KEY_W'(j) : KEY_W'($urandom);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset stack: zeros everywhere, key 0 matches an empty slot
        queue_op(FUNC_DUMP, '0);
        queue_op(FUNC_ACCESS, 16'h0000);
        queue_op(FUNC_ACCESS, 16'hFFFF);
        queue_op(FUNC_ACCESS, 16'h0001);
        queue_op(FUNC_ACCESS, 16'h8000);
        queue_op(FUNC_ACCESS, 16'h0001);
        queue_op(FUNC_ACCESS, 16'h0000);
        queue_op(FUNC_DUMP, 16'hFFFF);

        // Single slot: every access replaces slot 0
        write_size(SIZE_W'(1));
        queue_op(FUNC_ACCESS, 16'h1234);
        queue_op(FUNC_ACCESS, 16'h1234);
        queue_op(FUNC_ACCESS, 16'hABCD);
        queue_op(FUNC_DUMP, '0);

        // Size zero acts as one slot
        write_size(SIZE_W'(0));
        queue_op(FUNC_ACCESS, 16'h0005);
        queue_op(FUNC_DUMP, '0);

        // Oversize clamps to full capacity; untouched slots come back
        write_size('1);
        queue_op(FUNC_DUMP, '0);

        // Long receiver hold-off while the sender keeps offering
        write_size(SIZE_W'(16));
        idling = 1'b1;
        @(negedge i_clk);
        hold_request = 1'b1;
        for (int i = 0; i < 22; i++)
            queue_op((i % 11 == 0) ? FUNC_DUMP : FUNC_ACCESS, pick_key());

        // Random phases over a range of sizes, some without idling
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_size(SIZE_W'(PHASE_SIZES[p]));
            idling = (p % 3 != 1);
            for (int i = 0; i < PHASE_WORDS; i++)
                queue_op(($urandom_range(0, 5) == 0) ? FUNC_DUMP : FUNC_ACCESS, pick_key());
        end

        settle();
        repeat (8) @(posedge i_clk);
        $display("Covered %0d accesses (%0d hits) and %0d dumps, %0d slot words checked,",
                 access_count, hit_count, dump_count, words_checked);
        $display("over %0d active size writes including 0, 1, 16, 17 and 31.", cfg_writes);
        if (errors == 0) begin
            $display("lru_recency_stack_unit regression: pass");
        end else begin
            $display("%0d mismatches", errors);
            $display("lru_recency_stack_unit regression: fail");
        end
        $finish;
    end

endmodule

>>> lru_recency_stack_unit.f
rtl/lrs_pkg.sv
rtl/lrs_ctrl.sv
rtl/lrs_datapath.sv
rtl/lru_recency_stack_unit.sv
dv/tb_top.sv
